// File: rtl/gn3_pkg.sv
// Shared types, fixed-point constants and the gradient select function for the
// gradient noise pipeline. Depends on nothing.
package gn3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CELL_BITS = 8;

  // Unsigned fraction, signed corner offset, signed gradient dot product,
  // signed blended value and unsigned weight (0 to 1.0 inclusive).
  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic signed [FRAC_BITS:0]   off_t;
  typedef logic signed [FRAC_BITS+1:0] grad_t;
  typedef logic signed [FRAC_BITS+2:0] val_t;
  typedef logic [FRAC_BITS:0]          wt_t;
  typedef logic [CELL_BITS-1:0]        cell_t;

  localparam wt_t WT_ONE = wt_t'(1) << FRAC_BITS;

  // Term thresholds and codes that pick x as second term when upper bits are set.
  localparam logic [3:0] H_ALT_X0 = 4'd12;
  localparam logic [3:0] H_ALT_X1 = 4'd14;
  localparam logic [3:0] H_USE_Y  = 4'd8;
  localparam logic [3:0] H_V_Y    = 4'd4;

  // Dot product of the corner offset with the edge gradient that the code h picks.
  function automatic grad_t grad3(input logic [3:0] h, input off_t x, input off_t y,
                                  input off_t z);
    off_t  u;
    off_t  v;
    grad_t us;
    grad_t vs;
    u = (h < H_USE_Y) ? x : y;
    v = (h < H_V_Y) ? y : (((h == H_ALT_X0) || (h == H_ALT_X1)) ? x : z);
    us = grad_t'(u);
    vs = grad_t'(v);
    if (h[0]) us = -us;
    if (h[1]) vs = -vs;
    return us + vs;
  endfunction

endpackage

// File: rtl/gn3_perm_ram.sv
// One copy of the 256 x 8 permutation store with one write and two read ports.
// Depends on nothing; read data is registered under the read enable.
module gn3_perm_ram (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic       ren,
  input  logic [7:0] raddr_a,
  input  logic [7:0] raddr_b,
  output logic [7:0] rdata_a,
  output logic [7:0] rdata_b
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/gn3_fade.sv
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 with rounded products.
// Depends on gn3_pkg; stage enables come from the top level pipeline.
module gn3_fade
  import gn3_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] en,
  input  frac_t      f,
  output wt_t        fade_out
);

  localparam int FW = FRAC_BITS + 4;
  localparam logic [FW-1:0] ONE_W = FW'(1) << FRAC_BITS;
  localparam logic [2*FW-1:0] HALF = (2*FW)'(1) << (FRAC_BITS - 1);

  logic [FW-1:0]   sarg;
  logic [2*FW-1:0] p_s;
  logic [2*FW-1:0] p_c;
  logic [FW-1:0]   s1;
  logic [FW-1:0]   c1;
  frac_t           f1;
  logic [FW-1:0]   b_val;
  logic [2*FW-1:0] p_d;
  logic [FW-1:0]   d2;
  logic [FW-1:0]   b2;
  logic [2*FW-1:0] p_r;
  logic [FW-1:0]   r_val;

  assign sarg  = FW'(15) * ONE_W - FW'(6) * FW'(f);
  assign p_s   = (2*FW)'(f) * (2*FW)'(sarg) + HALF;
  assign p_c   = (2*FW)'(f) * (2*FW)'(f) + HALF;
  assign b_val = FW'(10) * ONE_W - s1;
  assign p_d   = (2*FW)'(c1) * (2*FW)'(f1) + HALF;
  assign p_r   = (2*FW)'(d2) * (2*FW)'(b2) + HALF;
  assign r_val = p_r[FRAC_BITS +: FW];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= p_s[FRAC_BITS +: FW];
      c1 <= p_c[FRAC_BITS +: FW];
      f1 <= f;
    end
    if (en[1]) begin
      d2 <= p_d[FRAC_BITS +: FW];
      b2 <= b_val;
    end
    if (en[2]) begin
      fade_out <= (r_val > FW'(WT_ONE)) ? WT_ONE : r_val[FRAC_BITS:0];
    end
  end

endmodule

// File: rtl/gn3_lerp.sv
// Two-stage linear blend a + round(t * (b - a)): product, then rounded sum.
// Depends on gn3_pkg; stage enables come from the top level pipeline.
module gn3_lerp
  import gn3_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,
  input  val_t       a,
  input  val_t       b,
  input  wt_t        t,
  output val_t       y
);

  localparam int PW = 2 * FRAC_BITS + 6;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [FRAC_BITS+3:0] diff;
  logic signed [FRAC_BITS+1:0] tt;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        rnd;
  val_t                        a_r;

  assign diff = {b[FRAC_BITS+2], b} - {a[FRAC_BITS+2], a};
  assign tt   = {1'b0, t};
  assign rnd  = (prod + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PW'(diff) * PW'(tt);
      a_r  <= a;
    end
    if (en[1]) begin
      y <= a_r + rnd[FRAC_BITS+2:0];
    end
  end

endmodule

// File: rtl/gradient_noise_3d_top.sv
// Top level of the 3D gradient noise block: pipeline control, permutation
// copies and corner gradients. Depends on gn3_pkg, gn3_perm_ram, gn3_fade, gn3_lerp.
//
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | tdata: perm_index, perm_value, x_coord, y_coord, z_coord; tuser: func
//  m_*     | out | tdata: noise_value, zero padded to 24 bits
//
// The pipeline has eleven register stages and accepts one transfer every cycle
// while no stall from the output reaches the first stage. The three chained
// table lookups take three stages, and the three fade stages run beside them.
// The gradient stage takes one, each of the three blend levels takes two, and
// the output register takes the last.
// Reset clears only the stage valid bits; the permutation copies keep whatever
// they hold and must be written before they are read.
// Each stage moves on when it is empty or the stage after it moves, so a stalled
// output fills bubbles first and drops or repeats nothing.
module gradient_noise_3d_top
  import gn3_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // perm_index, perm_value, x_coord, y_coord, z_coord
  input  logic [0:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata    // noise_value
);

  localparam int NST = 11;
  localparam logic FUNC_WRITE = 1'b0;

  // Stage enables and valid bits, index k is register stage k.
  logic [NST:1] en;
  logic [NST:1] vld;

  logic         func_in;
  cell_t        pidx_in;
  cell_t        pval_in;
  logic [31:0]  xc_in;
  logic [31:0]  yc_in;
  logic [31:0]  zc_in;

  assign func_in = s_tuser[0];
  assign pidx_in = s_tdata[7:0];
  assign pval_in = s_tdata[15:8];
  assign xc_in   = s_tdata[47:16];
  assign yc_in   = s_tdata[79:48];
  assign zc_in   = s_tdata[111:80];

  always_comb begin
    en[NST] = !vld[NST] || m_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  logic func1;
  logic func2;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      if (en[2]) vld[2] <= vld[1];
      // Write items finish once the last table copy has taken them.
      if (en[3]) vld[3] <= vld[2] && (func2 != FUNC_WRITE);
      for (int k = 4; k <= NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Payload carried through the lookup stages.
  cell_t pidx1, pval1, pidx2, pval2;
  cell_t ycell1, zcell1, zcell2;
  frac_t fx1, fy1, fz1, fx2, fy2, fz2, fx3, fy3, fz3;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      func1  <= func_in;
      pidx1  <= pidx_in;
      pval1  <= pval_in;
      ycell1 <= yc_in[FRAC_BITS +: CELL_BITS];
      zcell1 <= zc_in[FRAC_BITS +: CELL_BITS];
      fx1    <= xc_in[FRAC_BITS-1:0];
      fy1    <= yc_in[FRAC_BITS-1:0];
      fz1    <= zc_in[FRAC_BITS-1:0];
    end
    if (en[2]) begin
      func2  <= func1;
      pidx2  <= pidx1;
      pval2  <= pval1;
      zcell2 <= zcell1;
      fx2    <= fx1;
      fy2    <= fy1;
      fz2    <= fz1;
    end
    if (en[3]) begin
      fx3 <= fx2;
      fy3 <= fy2;
      fz3 <= fz2;
    end
  end

  // Every lookup level has its own copies of the table. A write item updates a
  // copy as it passes the stage that reads it, so each evaluate item sees the
  // table exactly as it stood when that item was accepted.
  cell_t xcell0;
  logic  we0, we1, we2;
  cell_t p_x, p_x1;
  assign xcell0 = xc_in[FRAC_BITS +: CELL_BITS];
  assign we0 = s_tvalid && s_tready && (func_in == FUNC_WRITE);
  assign we1 = en[2] && vld[1] && (func1 == FUNC_WRITE);
  assign we2 = en[3] && vld[2] && (func2 == FUNC_WRITE);

  gn3_perm_ram u_ram0 (
    .clk(clk), .we(we0), .waddr(pidx_in), .wdata(pval_in), .ren(en[1]),
    .raddr_a(xcell0), .raddr_b(xcell0 + 8'd1), .rdata_a(p_x), .rdata_b(p_x1)
  );

  cell_t a_h, b_h;
  cell_t p_a, p_a1, p_b, p_b1;
  assign a_h = p_x + ycell1;
  assign b_h = p_x1 + ycell1;

  gn3_perm_ram u_ram1a (
    .clk(clk), .we(we1), .waddr(pidx1), .wdata(pval1), .ren(en[2]),
    .raddr_a(a_h), .raddr_b(a_h + 8'd1), .rdata_a(p_a), .rdata_b(p_a1)
  );
  gn3_perm_ram u_ram1b (
    .clk(clk), .we(we1), .waddr(pidx1), .wdata(pval1), .ren(en[2]),
    .raddr_a(b_h), .raddr_b(b_h + 8'd1), .rdata_a(p_b), .rdata_b(p_b1)
  );

  // Second level hashes in order AA, AB, BA, BB; each copy also reads hash+1.
  cell_t h2 [4];
  cell_t hz0 [4];
  cell_t hz1 [4];
  assign h2[0] = p_a + zcell2;
  assign h2[1] = p_a1 + zcell2;
  assign h2[2] = p_b + zcell2;
  assign h2[3] = p_b1 + zcell2;

  for (genvar i = 0; i < 4; i++) begin : g_ram2
    gn3_perm_ram u_ram2 (
      .clk(clk), .we(we2), .waddr(pidx2), .wdata(pval2), .ren(en[3]),
      .raddr_a(h2[i]), .raddr_b(h2[i] + 8'd1), .rdata_a(hz0[i]), .rdata_b(hz1[i])
    );
  end

  // Fade weights run alongside the lookups and are ready at stage three.
  wt_t u3, v3, w3;
  gn3_fade u_fade_x (.clk(clk), .en(en[3:1]), .f(xc_in[FRAC_BITS-1:0]), .fade_out(u3));
  gn3_fade u_fade_y (.clk(clk), .en(en[3:1]), .f(yc_in[FRAC_BITS-1:0]), .fade_out(v3));
  gn3_fade u_fade_z (.clk(clk), .en(en[3:1]), .f(zc_in[FRAC_BITS-1:0]), .fade_out(w3));

  // Near offsets are the fractions; far offsets are fraction minus one, which
  // in two's complement is just the fraction with the sign bit set.
  off_t ox0, ox1, oy0, oy1, oz0, oz1;
  assign ox0 = {1'b0, fx3};
  assign ox1 = {1'b1, fx3};
  assign oy0 = {1'b0, fy3};
  assign oy1 = {1'b1, fy3};
  assign oz0 = {1'b0, fz3};
  assign oz1 = {1'b1, fz3};

  // Corner order: x pairs first, then y, then z.
  val_t g4 [8];
  wt_t  u4, v4, w4;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      g4[0] <= val_t'(grad3(hz0[0][3:0], ox0, oy0, oz0));
      g4[1] <= val_t'(grad3(hz0[2][3:0], ox1, oy0, oz0));
      g4[2] <= val_t'(grad3(hz0[1][3:0], ox0, oy1, oz0));
      g4[3] <= val_t'(grad3(hz0[3][3:0], ox1, oy1, oz0));
      g4[4] <= val_t'(grad3(hz1[0][3:0], ox0, oy0, oz1));
      g4[5] <= val_t'(grad3(hz1[2][3:0], ox1, oy0, oz1));
      g4[6] <= val_t'(grad3(hz1[1][3:0], ox0, oy1, oz1));
      g4[7] <= val_t'(grad3(hz1[3][3:0], ox1, oy1, oz1));
      u4 <= u3;
      v4 <= v3;
      w4 <= w3;
    end
  end

  wt_t v5, v6, w5, w6, w7, w8;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      v5 <= v4;
      w5 <= w4;
    end
    if (en[6]) begin
      v6 <= v5;
      w6 <= w5;
    end
    if (en[7]) w7 <= w6;
    if (en[8]) w8 <= w7;
  end

  val_t lx [4];
  for (genvar i = 0; i < 4; i++) begin : g_lx
    gn3_lerp u_lx (.clk(clk), .en(en[6:5]), .a(g4[2*i]), .b(g4[2*i+1]), .t(u4),
                   .y(lx[i]));
  end

  val_t ly0, ly1, res;
  gn3_lerp u_ly0 (.clk(clk), .en(en[8:7]), .a(lx[0]), .b(lx[1]), .t(v6), .y(ly0));
  gn3_lerp u_ly1 (.clk(clk), .en(en[8:7]), .a(lx[2]), .b(lx[3]), .t(v6), .y(ly1));
  gn3_lerp u_lz (.clk(clk), .en(en[10:9]), .a(ly0), .b(ly1), .t(w8), .y(res));

  // Map [-1, 1] onto [0, 1] in units of 2^-16, rounding half up, then saturate.
  localparam int SHR = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int SHL = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;
  localparam logic signed [39:0] HALF_O = (SHR > 0) ? (40'sd1 <<< (SHR - 1)) : 40'sd0;
  localparam logic signed [39:0] ONE_O = 40'sd1 <<< FRAC_BITS;
  localparam logic [39:0] SAT_MAX = 40'd65536;

  logic signed [39:0] s_ext;
  logic [39:0]        r_ext;
  logic [16:0]        noise_next;
  logic [16:0]        noise_value;

  always_comb begin
    s_ext = 40'(res) + ONE_O;
    r_ext = 40'(((s_ext + HALF_O) >>> SHR) <<< SHL);
    if (s_ext <= 40'sd0) begin
      noise_next = 17'd0;
    end else if (r_ext > SAT_MAX) begin
      noise_next = 17'(SAT_MAX);
    end else begin
      noise_next = r_ext[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) noise_value <= noise_next;
  end

  assign m_tvalid = vld[NST];
  assign m_tdata  = {7'd0, noise_value};

  // A full sixth stage that cannot move keeps its item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[6] && !en[6] |=> vld[6])
    else $error("stage six lost a stalled item");

  // An empty first stage always takes a transfer.
  a_take: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> s_tready)
    else $error("input refused while the first stage is empty");

  // Fade weights never pass 1.0 once an evaluate item holds them.
  a_fade: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (u4 <= WT_ONE) && (v4 <= WT_ONE) && (w4 <= WT_ONE))
    else $error("fade weight above one");

  // A result that leaves is within the saturation range.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:0] <= 17'd65536) && (m_tdata[23:17] == 7'd0))
    else $error("noise value out of range");

endmodule
